FILE: design/layer_map_and_precode_defines.svh
// Assertion macros shared by the checker files of the layer mapper.
// Stands alone; the user scope must provide clk and rst_n.
`ifndef LAYER_MAP_AND_PRECODE_DEFINES_SVH
`define LAYER_MAP_AND_PRECODE_DEFINES_SVH

// Check a consequent in the same cycle as the antecedent.
`define LMP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after the antecedent.
`define LMP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/lmp_pkg.sv
// Package for the layer mapper and precoder: sizes, codes and the lane control type.
// No dependencies.
package lmp_pkg;

    localparam int MAX_PORTS        = 4;
    localparam int MAX_LAYERS       = 4;
    localparam int WEIGHT_FRAC_BITS = 14;

    localparam int SYM_W    = 8;
    localparam int WEIGHT_W = 16;
    localparam int ACC_W    = 26;
    localparam int PROD_W   = SYM_W + WEIGHT_W;
    localparam int CFG_W    = 3;
    localparam int PORT_W   = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;
    localparam int LAYER_W  = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int CNT_W    = $clog2(MAX_PORTS + 1);

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 56;

    // Opcodes carried in the input tuser
    localparam logic OP_WEIGHT = 1'b0;
    localparam logic OP_SYMBOL = 1'b1;

    // Configuration register indexes
    localparam logic CFG_NUM_LAYERS = 1'b0;
    localparam logic CFG_NUM_PORTS  = 1'b1;

    // Controls and data broadcast to every port lane
    typedef struct packed {
        logic                       sym_en;
        logic                       first;
        logic [LAYER_W-1:0]         layer;
        logic [LAYER_W-1:0]         w_layer;
        logic signed [SYM_W-1:0]    sym_re;
        logic signed [SYM_W-1:0]    sym_im;
        logic signed [WEIGHT_W-1:0] w_re;
        logic signed [WEIGHT_W-1:0] w_im;
    } lmp_ctl_t;

endpackage

FILE: design/lmp_lane.sv
// One antenna port lane: weight column, complex multiply and accumulator.
// Depends on lmp_pkg.
module lmp_lane
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  lmp_pkg::lmp_ctl_t                   ctl,
    input  logic                                wr_sel,
    output logic signed [lmp_pkg::ACC_W-1:0]    acc_re_new,
    output logic signed [lmp_pkg::ACC_W-1:0]    acc_im_new
);

    logic signed [lmp_pkg::WEIGHT_W-1:0] w_re_reg [lmp_pkg::MAX_LAYERS];
    logic signed [lmp_pkg::WEIGHT_W-1:0] w_im_reg [lmp_pkg::MAX_LAYERS];
    logic signed [lmp_pkg::ACC_W-1:0]    acc_re_reg;
    logic signed [lmp_pkg::ACC_W-1:0]    acc_im_reg;

    logic signed [lmp_pkg::WEIGHT_W-1:0] c;
    logic signed [lmp_pkg::WEIGHT_W-1:0] d;
    logic signed [lmp_pkg::PROD_W-1:0]   ac;
    logic signed [lmp_pkg::PROD_W-1:0]   bd;
    logic signed [lmp_pkg::PROD_W-1:0]   ad;
    logic signed [lmp_pkg::PROD_W-1:0]   bc;
    logic signed [lmp_pkg::ACC_W-1:0]    pr;
    logic signed [lmp_pkg::ACC_W-1:0]    pi;

    always_comb
    begin
        c  = w_re_reg[ctl.layer];
        d  = w_im_reg[ctl.layer];
        ac = ctl.sym_re * c;
        bd = ctl.sym_im * d;
        ad = ctl.sym_re * d;
        bc = ctl.sym_im * c;
        pr = lmp_pkg::ACC_W'(ac) - lmp_pkg::ACC_W'(bd);
        pi = lmp_pkg::ACC_W'(ad) + lmp_pkg::ACC_W'(bc);
        // restart the sum on layer zero
        acc_re_new = ctl.first ? pr : acc_re_reg + pr;
        acc_im_new = ctl.first ? pi : acc_im_reg + pi;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < lmp_pkg::MAX_LAYERS; l++)
            begin
                w_re_reg[l] <= '0;
                w_im_reg[l] <= '0;
            end
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else
        begin
            if (wr_sel)
            begin
                w_re_reg[ctl.w_layer] <= ctl.w_re;
                w_im_reg[ctl.w_layer] <= ctl.w_im;
            end
            if (ctl.sym_en)
            begin
                acc_re_reg <= acc_re_new;
                acc_im_reg <= acc_im_new;
            end
        end
    end

endmodule

FILE: design/layer_map_and_precode.sv
// Timing: a symbol item is registered, then multiplied and summed while held there;
// the result bank loads an element's sums, its first port result, as its last layer moves on.
// Throughput: one input item per cycle; each element emits num_ports results, one per
// cycle from the result bank while m_tready is high, so the input stalls when an
// element completes before the previous element's results have drained.
// Reset (rst_n, asynchronous): weights and sums zero, layer counter zero, both counts one.
module layer_map_and_precode
(
    input  logic                              clk,
    input  logic                              rst_n,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [7:0] sym_re, [15:8] sym_im, [17:16] weight_port, [19:18] weight_layer,
    // [35:20] weight_re, [51:36] weight_im, [55:52] zero
    input  logic [lmp_pkg::IN_DATA_W-1:0]     s_tdata,
    // [0] opcode
    input  logic [0:0]                        s_tuser,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [25:0] out_re, [51:26] out_im, [55:52] zero
    output logic [lmp_pkg::OUT_DATA_W-1:0]    m_tdata,
    // [1:0] port_index
    output logic [lmp_pkg::PORT_W-1:0]        m_tuser,
    output logic                              m_tlast,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [0:0]                        cfg_addr,
    input  logic [lmp_pkg::CFG_W-1:0]         cfg_wdata
);

    localparam int PAD_W = lmp_pkg::OUT_DATA_W - 2 * lmp_pkg::ACC_W;

    // configuration, held already clamped to the legal range
    logic [lmp_pkg::CFG_W-1:0]      nl_reg;
    logic [lmp_pkg::CFG_W-1:0]      np_reg;
    logic [lmp_pkg::CFG_W-1:0]      cfg_clamp_l;
    logic [lmp_pkg::CFG_W-1:0]      cfg_clamp_p;

    // input register
    logic                            s1_valid_reg;
    logic                            s1_op_reg;
    logic [lmp_pkg::IN_DATA_W-1:0]   s1_data_reg;

    logic [lmp_pkg::LAYER_W-1:0]     layer_count_reg;
    logic [lmp_pkg::LAYER_W-1:0]     layer;
    logic                            completing;
    logic                            bank_free;
    logic                            s1_go;
    logic                            m_accept;
    logic                            s_accept;

    lmp_pkg::lmp_ctl_t               ctl;
    logic [lmp_pkg::PORT_W-1:0]      w_port;
    logic [lmp_pkg::MAX_PORTS-1:0]   wr_sel;

    logic signed [lmp_pkg::ACC_W-1:0] acc_re_new [lmp_pkg::MAX_PORTS];
    logic signed [lmp_pkg::ACC_W-1:0] acc_im_new [lmp_pkg::MAX_PORTS];

    // result bank: entry 0 is on the output, shift down as results are taken
    logic signed [lmp_pkg::ACC_W-1:0] bank_re_reg [lmp_pkg::MAX_PORTS];
    logic signed [lmp_pkg::ACC_W-1:0] bank_im_reg [lmp_pkg::MAX_PORTS];
    logic [lmp_pkg::CNT_W-1:0]        bank_cnt_reg;
    logic [lmp_pkg::PORT_W-1:0]       bank_port_reg;

    // clamp register writes to 1..MAX
    always_comb
    begin
        if (cfg_wdata == '0)
            cfg_clamp_l = lmp_pkg::CFG_W'(1);
        else if (cfg_wdata > lmp_pkg::CFG_W'(lmp_pkg::MAX_LAYERS))
            cfg_clamp_l = lmp_pkg::CFG_W'(lmp_pkg::MAX_LAYERS);
        else
            cfg_clamp_l = cfg_wdata;

        if (cfg_wdata == '0)
            cfg_clamp_p = lmp_pkg::CFG_W'(1);
        else if (cfg_wdata > lmp_pkg::CFG_W'(lmp_pkg::MAX_PORTS))
            cfg_clamp_p = lmp_pkg::CFG_W'(lmp_pkg::MAX_PORTS);
        else
            cfg_clamp_p = cfg_wdata;
    end

    assign m_accept = m_tvalid && m_tready;
    assign s_accept = s_tvalid && s_tready;

    // Wrap a stale layer counter (count lowered by config) back to zero.
    always_comb
    begin
        if (lmp_pkg::CFG_W'(layer_count_reg) >= nl_reg)
            layer = '0;
        else
            layer = layer_count_reg;
    end

    // The last layer of an element needs the bank empty, or emptying this cycle.
    assign completing = s1_valid_reg && (s1_op_reg == lmp_pkg::OP_SYMBOL) &&
                        (layer == lmp_pkg::LAYER_W'(nl_reg - lmp_pkg::CFG_W'(1)));
    assign bank_free  = (bank_cnt_reg == '0) ||
                        ((bank_cnt_reg == lmp_pkg::CNT_W'(1)) && m_accept);
    assign s1_go      = !completing || bank_free;
    assign s_tready   = !s1_valid_reg || s1_go;

    // unpack the held item and broadcast to the lanes
    always_comb
    begin
        ctl.sym_en  = s1_valid_reg && (s1_op_reg == lmp_pkg::OP_SYMBOL) && s1_go;
        ctl.first   = (layer == '0);
        ctl.layer   = layer;
        ctl.sym_re  = s1_data_reg[7:0];
        ctl.sym_im  = s1_data_reg[15:8];
        ctl.w_layer = s1_data_reg[19:18];
        ctl.w_re    = s1_data_reg[35:20];
        ctl.w_im    = s1_data_reg[51:36];
        w_port      = s1_data_reg[17:16];
        for (int p = 0; p < lmp_pkg::MAX_PORTS; p++)
            wr_sel[p] = s1_valid_reg && (s1_op_reg == lmp_pkg::OP_WEIGHT) &&
                        (w_port == lmp_pkg::PORT_W'(p));
    end

    for (genvar p = 0; p < lmp_pkg::MAX_PORTS; p++)
    begin : g_lane
        lmp_lane u_lane
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .wr_sel     (wr_sel[p]),
            .acc_re_new (acc_re_new[p]),
            .acc_im_new (acc_im_new[p])
        );
    end

    // configuration and layer counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nl_reg          <= lmp_pkg::CFG_W'(1);
            np_reg          <= lmp_pkg::CFG_W'(1);
            layer_count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            // any register write restarts the element
            unique case (cfg_addr)
                lmp_pkg::CFG_NUM_LAYERS: nl_reg <= cfg_clamp_l;
                lmp_pkg::CFG_NUM_PORTS:  np_reg <= cfg_clamp_p;
                default: ;
            endcase
            layer_count_reg <= '0;
        end
        else if (ctl.sym_en)
        begin
            layer_count_reg <= completing ? '0 : layer + lmp_pkg::LAYER_W'(1);
        end
    end

    // input register: take a new item whenever the held one moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_tready)
            s1_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_op_reg   <= s_tuser[0];
            s1_data_reg <= s_tdata;
        end
    end

    // result bank: load on element completion, else shift on each taken result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_cnt_reg  <= '0;
            bank_port_reg <= '0;
        end
        else if (ctl.sym_en && completing)
        begin
            bank_cnt_reg  <= lmp_pkg::CNT_W'(np_reg);
            bank_port_reg <= '0;
        end
        else if (m_accept)
        begin
            bank_cnt_reg  <= bank_cnt_reg - lmp_pkg::CNT_W'(1);
            bank_port_reg <= bank_port_reg + lmp_pkg::PORT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sym_en && completing)
        begin
            for (int p = 0; p < lmp_pkg::MAX_PORTS; p++)
            begin
                bank_re_reg[p] <= acc_re_new[p];
                bank_im_reg[p] <= acc_im_new[p];
            end
        end
        else if (m_accept)
        begin
            for (int p = 0; p < lmp_pkg::MAX_PORTS - 1; p++)
            begin
                bank_re_reg[p] <= bank_re_reg[p + 1];
                bank_im_reg[p] <= bank_im_reg[p + 1];
            end
        end
    end

    assign m_tvalid = (bank_cnt_reg != '0);
    assign m_tdata  = {PAD_W'(0), bank_im_reg[0], bank_re_reg[0]};
    assign m_tuser  = bank_port_reg;
    assign m_tlast  = (bank_cnt_reg == lmp_pkg::CNT_W'(1));

endmodule

FILE: design/lmp_checker.sv
// Port-level checker for the layer mapper, bound to the top level.
// Depends on lmp_pkg and layer_map_and_precode_defines.svh.
`include "layer_map_and_precode_defines.svh"

module lmp_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tready,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [lmp_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic [lmp_pkg::PORT_W-1:0]        m_tuser,
    input  logic                              m_tlast
);

    // a stalled result holds
    `LMP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

    // ports of one element follow in order without gaps
    `LMP_ASSERT_NEXT(a_port_seq, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tuser == $past(m_tuser) + 1'b1), "port sequence broken")

    // a new element starts at port zero
    `LMP_ASSERT_NEXT(a_port_restart, m_tvalid && m_tready && m_tlast, !m_tvalid || (m_tuser == '0), "element did not start at port zero")

    // with nothing waiting at the output the input never stalls
    `LMP_ASSERT_SAME(a_ready_idle, !m_tvalid, s_tready, "input stalled with empty output")

endmodule

bind layer_map_and_precode lmp_checker u_lmp_checker (.*);
